// ----- rtl/core/pair_distance_histogram_top_macros.svh -----
// Assertion macros used by the pair distance histogram top level.
`ifndef PAIR_DISTANCE_HISTOGRAM_TOP_MACROS_SVH
`define PAIR_DISTANCE_HISTOGRAM_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define PDH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdh assertion failed");
// Next-cycle implication.
`define PDH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdh assertion failed");
`else
`define PDH_ASSERT_NOW(label, ante, cons)
`define PDH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/core/pdh_pkg.sv -----
// Types, constants and helpers of the pair distance histogram.
package pdh_pkg;

    localparam int BINS       = 32;
    localparam int COORD_BITS = 24;
    localparam int NCELL      = BINS + 1;

    localparam int COORD_W = 24;
    localparam int IDX_W   = 7;
    localparam int EDGE_W  = 52;
    localparam int BIN_W   = 6;
    localparam int CNT_W   = 40;
    localparam int MAG_W   = COORD_BITS;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int D2_W    = 2 * COORD_BITS + 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] ACT_EDGE = 2'd0;
    localparam logic [1:0] ACT_PAIR = 2'd1;
    localparam logic [1:0] ACT_DUMP = 2'd2;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_DUMP
    } pdh_state_t;

    // One transaction moving down the edge chain.
    typedef struct packed {
        logic              vld;
        logic              is_pair;
        logic [IDX_W-1:0]  idx;
        logic [EDGE_W-1:0] val;
        logic [BIN_W-1:0]  bin;
        logic              ok;
    } pdh_tok_t;

    // Magnitude of the difference of two coordinates, low COORD_BITS bits used.
    function automatic logic [MAG_W-1:0] mag_of(input logic [COORD_W-1:0] a,
                                               input logic [COORD_W-1:0] b);
        logic signed [COORD_BITS:0] d;
        d = $signed({a[COORD_BITS-1], a[COORD_BITS-1:0]})
            - $signed({b[COORD_BITS-1], b[COORD_BITS-1:0]});
        if (d[COORD_BITS])
        begin
            mag_of = MAG_W'(-d);
        end
        else
        begin
            mag_of = MAG_W'(d);
        end
    endfunction

endpackage

// ----- rtl/core/pdh_sq.sv -----
// Squared separation pipeline: difference, square, sum; edge writes pass their value through.
module pdh_sq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        vld,
    input  logic                        is_pair,
    input  logic [pdh_pkg::IDX_W-1:0]   idx,
    input  logic [pdh_pkg::EDGE_W-1:0]  edge_value,
    input  logic [pdh_pkg::COORD_W-1:0] a_x,
    input  logic [pdh_pkg::COORD_W-1:0] a_y,
    input  logic [pdh_pkg::COORD_W-1:0] a_z,
    input  logic [pdh_pkg::COORD_W-1:0] b_x,
    input  logic [pdh_pkg::COORD_W-1:0] b_y,
    input  logic [pdh_pkg::COORD_W-1:0] b_z,
    output pdh_pkg::pdh_tok_t           tok,
    output logic                        busy
);

    // stage 1: magnitudes
    logic                        v1_reg, p1_reg;
    logic [pdh_pkg::IDX_W-1:0]   i1_reg;
    logic [pdh_pkg::EDGE_W-1:0]  e1_reg;
    logic [pdh_pkg::MAG_W-1:0]   mx_reg, my_reg, mz_reg;
    // stage 2: squares
    logic                        v2_reg, p2_reg;
    logic [pdh_pkg::IDX_W-1:0]   i2_reg;
    logic [pdh_pkg::EDGE_W-1:0]  e2_reg;
    logic [pdh_pkg::SQ_W-1:0]    sx_reg, sy_reg, sz_reg;
    // stage 3: sum or edge value
    pdh_pkg::pdh_tok_t           tok_reg, tok_next;
    logic [pdh_pkg::D2_W-1:0]    d2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= vld;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= is_pair;
        i1_reg <= idx;
        e1_reg <= edge_value;
        mx_reg <= pdh_pkg::mag_of(a_x, b_x);
        my_reg <= pdh_pkg::mag_of(a_y, b_y);
        mz_reg <= pdh_pkg::mag_of(a_z, b_z);
        p2_reg <= p1_reg;
        i2_reg <= i1_reg;
        e2_reg <= e1_reg;
        sx_reg <= pdh_pkg::SQ_W'(mx_reg) * pdh_pkg::SQ_W'(mx_reg);
        sy_reg <= pdh_pkg::SQ_W'(my_reg) * pdh_pkg::SQ_W'(my_reg);
        sz_reg <= pdh_pkg::SQ_W'(mz_reg) * pdh_pkg::SQ_W'(mz_reg);
    end

    always_comb
    begin
        d2 = pdh_pkg::D2_W'(sx_reg) + pdh_pkg::D2_W'(sy_reg) + pdh_pkg::D2_W'(sz_reg);
        tok_next.vld     = v2_reg;
        tok_next.is_pair = p2_reg;
        tok_next.idx     = i2_reg;
        tok_next.val     = p2_reg ? {(pdh_pkg::EDGE_W - pdh_pkg::D2_W)'(0), d2} : e2_reg;
        tok_next.bin     = '0;
        tok_next.ok      = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok  = tok_reg;
    assign busy = v1_reg | v2_reg | tok_reg.vld;

endmodule

// ----- rtl/core/pdh_edge_cell.sv -----
// One edge cell: holds one squared edge, updates the passing transaction.
module pdh_edge_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [pdh_pkg::IDX_W-1:0] my_idx,
    input  pdh_pkg::pdh_tok_t         tok_in,
    output pdh_pkg::pdh_tok_t         tok_out
);

    logic [pdh_pkg::EDGE_W-1:0] edge_reg, edge_next;
    pdh_pkg::pdh_tok_t          tok_reg, tok_next;
    logic                       ge;

    always_comb
    begin
        ge        = (edge_reg <= tok_in.val);
        tok_next  = tok_in;
        edge_next = edge_reg;
        if (tok_in.vld && !tok_in.is_pair && (tok_in.idx == my_idx))
        begin
            edge_next = tok_in.val;
        end
        if (tok_in.is_pair)
        begin
            // lower bound, upper bound, or one interior edge
            priority if (my_idx == '0)
            begin
                tok_next.ok = ge;
            end
            else if (my_idx == pdh_pkg::IDX_W'(pdh_pkg::BINS))
            begin
                tok_next.ok = tok_in.ok & ~ge;
            end
            else
            begin
                tok_next.bin = tok_in.bin + pdh_pkg::BIN_W'(ge);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/core/pdh_count_cell.sv -----
// One count cell: saturating bin counter that shifts toward the output on a dump.
module pdh_count_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      hit,
    input  logic                      shift,
    input  logic [pdh_pkg::CNT_W-1:0] cnt_in,
    output logic [pdh_pkg::CNT_W-1:0] cnt
);

    logic [pdh_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        priority if (shift)
        begin
            cnt_next = cnt_in;
        end
        else if (hit && (cnt_reg != pdh_pkg::CNT_MAX))
        begin
            cnt_next = cnt_reg + pdh_pkg::CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

// ----- rtl/core/pair_distance_histogram_top.sv -----
// Top level of the pair distance histogram.
//
// Pair distance histogram. Each input transaction carries an action in
// s_tuser: write one squared bin edge, count one point pair, or dump and
// clear all bin counts (the fourth code is accepted and dropped). Edge writes
// and pairs are taken one per cycle outside a dump: a pair first runs through
// a three-stage difference/square/sum pipeline, then its squared separation
// walks a chain of BINS+1 edge cells, one cell per cycle, each holding one
// squared edge. The first cell checks the lower bound, the last the upper
// bound, and each interior cell adds one to the running bin number when its
// edge is at or below the separation. Edge writes walk the same chain, so
// every pair sees exactly the edges written before it. Behind the chain sits
// a row of saturating 40-bit count cells; the one matching the bin counts up.
// Edge entries are undefined until written and must be loaded before pairs
// are sent. A dump stops input (s_tready low) until the dump ends; it waits
// for the pipeline to empty, then emits BINS results, bin 0 first, one per
// cycle while m_tready is high, with tlast on the final bin; the count cells
// shift toward the output and fill with zeros, so the counts are clear when
// the dump ends.
`include "pair_distance_histogram_top_macros.svh"

module pair_distance_histogram_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // edge_index[6:0], edge_value[58:7], a_x[82:59], a_y[106:83], a_z[130:107],
    // b_x[154:131], b_y[178:155], b_z[202:179], zero fill [207:203]
    input  logic [207:0] s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // bin[5:0], count[45:6], zero fill [47:46]
    output logic [47:0]  m_tdata,
    output logic         m_tlast
);

    pdh_pkg::pdh_state_t        state_reg, state_next;
    logic [pdh_pkg::BIN_W-1:0]  dump_reg, dump_next;

    logic                       s_fire, m_fire, front_vld, front_busy, busy, shift, cnt_any;
    logic                       dump_last;
    pdh_pkg::pdh_tok_t          chain [pdh_pkg::NCELL+1];
    logic [pdh_pkg::NCELL-1:0]  cell_vld;
    logic [pdh_pkg::CNT_W-1:0]  cnt [pdh_pkg::BINS+1];

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign front_vld = s_fire && ((s_tuser == pdh_pkg::ACT_EDGE) ||
                                  (s_tuser == pdh_pkg::ACT_PAIR));

    // front end: squared separation
    pdh_sq u_sq (
        .clk        (clk),
        .rst_n      (rst_n),
        .vld        (front_vld),
        .is_pair    (s_tuser == pdh_pkg::ACT_PAIR),
        .idx        (s_tdata[6:0]),
        .edge_value (s_tdata[58:7]),
        .a_x        (s_tdata[82:59]),
        .a_y        (s_tdata[106:83]),
        .a_z        (s_tdata[130:107]),
        .b_x        (s_tdata[154:131]),
        .b_y        (s_tdata[178:155]),
        .b_z        (s_tdata[202:179]),
        .tok        (chain[0]),
        .busy       (front_busy)
    );

    // edge chain
    for (genvar i = 0; i < pdh_pkg::NCELL; i++)
    begin : g_edge
        pdh_edge_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .my_idx  (pdh_pkg::IDX_W'(i)),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
        assign cell_vld[i] = chain[i+1].vld;
    end

    // count cells; cell k takes its right neighbor on a shift, the last takes zero
    assign cnt[pdh_pkg::BINS] = '0;
    assign shift = m_fire;

    for (genvar k = 0; k < pdh_pkg::BINS; k++)
    begin : g_count
        pdh_count_cell u_cnt (
            .clk    (clk),
            .rst_n  (rst_n),
            .hit    (chain[pdh_pkg::NCELL].vld && chain[pdh_pkg::NCELL].is_pair &&
                     chain[pdh_pkg::NCELL].ok &&
                     (chain[pdh_pkg::NCELL].bin == pdh_pkg::BIN_W'(k))),
            .shift  (shift),
            .cnt_in (cnt[k+1]),
            .cnt    (cnt[k])
        );
    end

    assign busy      = front_busy | (|cell_vld);
    assign dump_last = (dump_reg == pdh_pkg::BIN_W'(pdh_pkg::BINS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdh_pkg::ST_RUN;
            dump_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dump_reg  <= dump_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dump_next  = dump_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            pdh_pkg::ST_RUN:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == pdh_pkg::ACT_DUMP))
                begin
                    state_next = pdh_pkg::ST_DRAIN;
                end
            end
            pdh_pkg::ST_DRAIN:
            begin
                // hold until every in-flight transaction has reached the counters
                if (!busy)
                begin
                    state_next = pdh_pkg::ST_DUMP;
                    dump_next  = '0;
                end
            end
            pdh_pkg::ST_DUMP:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    dump_next = dump_reg + pdh_pkg::BIN_W'(1);
                    if (dump_last)
                    begin
                        state_next = pdh_pkg::ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = pdh_pkg::ST_RUN;
            end
        endcase
    end

    assign m_tdata = {2'b00, cnt[0], dump_reg};
    assign m_tlast = dump_last;

    always_comb
    begin
        cnt_any = 1'b0;
        for (int k = 0; k < pdh_pkg::BINS; k++)
        begin
            cnt_any = cnt_any | (|cnt[k]);
        end
    end

    `PDH_ASSERT_NOW(a_dump_idle, state_reg == pdh_pkg::ST_DUMP, !busy)
    `PDH_ASSERT_NEXT(a_dump_end, m_fire && m_tlast, state_reg == pdh_pkg::ST_RUN)
    `PDH_ASSERT_NEXT(a_dump_cont, m_fire && !m_tlast, m_tvalid)
    `PDH_ASSERT_NEXT(a_dump_clear, m_fire && m_tlast, !cnt_any)

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the pair distance histogram top level.
module tb;

    // Action code that the block must accept and drop.
    localparam logic [1:0] ACT_NONE = 2'd3;

    // Kinds of edge table that load_edges can write.
    localparam int SET_LINEAR    = 0;
    localparam int SET_LOG       = 1;
    localparam int SET_SCRAMBLED = 2;

    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 27;
    localparam int REPORT_LIMIT = 40;

    localparam logic signed [pdh_pkg::COORD_W-1:0] C_MIN =
        {1'b1, {(pdh_pkg::COORD_W-1){1'b0}}};
    localparam logic signed [pdh_pkg::COORD_W-1:0] C_MAX =
        {1'b0, {(pdh_pkg::COORD_W-1){1'b1}}};
    localparam logic [pdh_pkg::EDGE_W-1:0] EDGE_TOP = {pdh_pkg::EDGE_W{1'b1}};

    typedef struct {
        logic [1:0]                         action;
        logic [pdh_pkg::IDX_W-1:0]          idx;
        logic [pdh_pkg::EDGE_W-1:0]         val;
        logic signed [pdh_pkg::COORD_W-1:0] a [3];
        logic signed [pdh_pkg::COORD_W-1:0] b [3];
    } pdh_cmd_t;

    typedef struct {
        logic [pdh_pkg::BIN_W-1:0] bin;
        logic [pdh_pkg::CNT_W-1:0] count;
        logic                      last;
    } bin_beat_t;

    // Directed row; a typed dump carries its counts for bin 0 and the top bin,
    // every other bin is expected at zero.
    typedef struct {
        pdh_cmd_t cmd;
        bit       typed;
        int       lo_cnt;
        int       hi_cnt;
    } dir_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         m_tlast;

    // Mirror of the block state, updated on every accepted transaction.
    logic [pdh_pkg::EDGE_W-1:0] edge_tbl [pdh_pkg::BINS+1];
    logic [pdh_pkg::CNT_W-1:0]  bin_tally [pdh_pkg::BINS];

    bin_beat_t pending_counts [$];
    dir_row_t  dir_tab [$];

    int mismatches    = 0;
    int burst_left    = 4;
    int hold_left     = 0;
    bit long_hold_due = 1'b0;

    always #10 clk = ~clk;

    pair_distance_histogram_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Append one expected count at the tail of the queue.
    function automatic void queue_beat(input bin_beat_t beat);
        pending_counts.insert(pending_counts.size(), beat);
    endfunction

    // Append one directed row at the tail of the table.
    function automatic void add_row(input dir_row_t row);
        dir_tab.insert(dir_tab.size(), row);
    endfunction

    // Update the mirrored state for one transaction and, when asked, queue the
    // counts that a dump emits.
    function automatic void apply_to_histogram(input pdh_cmd_t c, input bit keep);
        longint                     diff;
        logic [pdh_pkg::EDGE_W-1:0] d2;
        int                         hit;
        bin_beat_t                  beat;
        case (c.action)
            pdh_pkg::ACT_EDGE:
            begin
                if (c.idx <= pdh_pkg::BINS)
                begin
                    edge_tbl[c.idx] = c.val;
                end
            end
            pdh_pkg::ACT_PAIR:
            begin
                d2 = '0;
                for (int k = 0; k < 3; k++)
                begin
                    diff = c.a[k] - c.b[k];
                    d2 = d2 + pdh_pkg::EDGE_W'(diff * diff);
                end
                // Count only inside the outer edges; the bin is the number of
                // interior edges at or below d2, whatever their order.
                if (d2 >= edge_tbl[0] && d2 < edge_tbl[pdh_pkg::BINS])
                begin
                    hit = 0;
                    for (int k = 1; k < pdh_pkg::BINS; k++)
                    begin
                        if (edge_tbl[k] <= d2)
                        begin
                            hit++;
                        end
                    end
                    if (bin_tally[hit] != pdh_pkg::CNT_MAX)
                    begin
                        bin_tally[hit]++;
                    end
                end
            end
            pdh_pkg::ACT_DUMP:
            begin
                for (int k = 0; k < pdh_pkg::BINS; k++)
                begin
                    beat.bin   = pdh_pkg::BIN_W'(k);
                    beat.count = bin_tally[k];
                    beat.last  = (k == pdh_pkg::BINS - 1);
                    if (keep)
                    begin
                        queue_beat(beat);
                    end
                    bin_tally[k] = '0;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic pdh_cmd_t mk_pair(
        input logic signed [pdh_pkg::COORD_W-1:0] ax, ay, az,
        input logic signed [pdh_pkg::COORD_W-1:0] bx, by, bz);
        pdh_cmd_t c;
        c.action = pdh_pkg::ACT_PAIR;
        c.idx    = '0;
        c.val    = '0;
        c.a[0] = ax; c.a[1] = ay; c.a[2] = az;
        c.b[0] = bx; c.b[1] = by; c.b[2] = bz;
        return c;
    endfunction

    function automatic pdh_cmd_t mk_edge(input logic [pdh_pkg::IDX_W-1:0] idx,
                                         input logic [pdh_pkg::EDGE_W-1:0] val);
        pdh_cmd_t c;
        c = mk_pair(0, 0, 0, 0, 0, 0);
        c.action = pdh_pkg::ACT_EDGE;
        c.idx    = idx;
        c.val    = val;
        return c;
    endfunction

    // Random pair; mostly nearby points with a random spread per axis so that
    // separations cover many octaves. Unused fields carry noise.
    function automatic pdh_cmd_t rand_pair();
        pdh_cmd_t                    c;
        int                          w;
        logic [pdh_pkg::COORD_W-1:0] delta;
        c = mk_pair(0, 0, 0, 0, 0, 0);
        c.idx = pdh_pkg::IDX_W'($urandom_range(0, 127));
        c.val = pdh_pkg::EDGE_W'({$urandom, $urandom});
        for (int k = 0; k < 3; k++)
        begin
            c.a[k] = pdh_pkg::COORD_W'($urandom);
            if ($urandom_range(0, 7) == 0)
            begin
                c.b[k] = pdh_pkg::COORD_W'($urandom);
            end
            else
            begin
                w = $urandom_range(0, pdh_pkg::COORD_W - 1);
                delta = pdh_pkg::COORD_W'($urandom & ((32'd1 << w) - 1));
                c.b[k] = $urandom_range(0, 1) ? c.a[k] - delta : c.a[k] + delta;
            end
        end
        return c;
    endfunction

    // Offer one transaction, wait for the handshake, then predict. Valid stays
    // high into the next call unless the burst ends here.
    task automatic offer(input pdh_cmd_t c, input bit keep);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= c.action;
        s_tdata  <= 208'({c.b[2], c.b[1], c.b[0], c.a[2], c.a[1], c.a[0], c.val, c.idx});
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        apply_to_histogram(c, keep);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write every edge of the chosen kind, edge 0 through edge BINS.
    task automatic load_edges(input int kind);
        logic [63:0] base;
        logic [63:0] e;
        int          s;
        s = $urandom_range(10, 18);
        for (int k = 0; k <= pdh_pkg::BINS; k++)
        begin
            case (kind)
                SET_LINEAR:
                begin
                    e = (k == 0) ? 64'd0
                      : (k == pdh_pkg::BINS) ? 64'(EDGE_TOP) : 64'(k) << 42;
                end
                SET_LOG:
                begin
                    // Edge k lies in [2^(s+k), 1.5*2^(s+k)), so the set rises.
                    base = 64'd1 << (s + k);
                    e = base + ({$urandom, $urandom} % (base >> 1));
                end
                default:
                begin
                    e = {$urandom, $urandom};
                end
            endcase
            offer(mk_edge(pdh_pkg::IDX_W'(k), pdh_pkg::EDGE_W'(e)), 1'b1);
        end
    endtask

    // Drop valid and hold until every queued count has come out.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic void report_mismatch(input string what, input logic [63:0] want,
                                            input logic [63:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // Receiver: apply one of four randomly chosen ready patterns; on request, hold
    // off for a long stretch so the block backs up into its input.
    initial
    begin : receiver
        int rx_mode;
        int rx_tick;
        rx_mode = 0;
        rx_tick = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                m_tready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                rx_tick++;
                if (rx_tick % 64 == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                end
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 9) != 0);
                    default: m_tready <= (rx_tick % 3 == 0);
                endcase
            end
        end
    end

    // Compare every accepted result with the oldest queued count.
    always @(posedge clk)
    begin : watch_results
        bin_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_counts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: unexpected result, expected none, actual bin %0d count %0d",
                             $time, m_tdata[pdh_pkg::BIN_W-1:0],
                             m_tdata[pdh_pkg::BIN_W +: pdh_pkg::CNT_W]);
                end
            end
            else
            begin
                want = pending_counts.pop_front();
                if (m_tdata[pdh_pkg::BIN_W-1:0] !== want.bin)
                begin
                    report_mismatch("bin", want.bin, m_tdata[pdh_pkg::BIN_W-1:0]);
                end
                if (m_tdata[pdh_pkg::BIN_W +: pdh_pkg::CNT_W] !== want.count)
                begin
                    report_mismatch("count", want.count,
                                    m_tdata[pdh_pkg::BIN_W +: pdh_pkg::CNT_W]);
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch("last", want.last, m_tlast);
                end
            end
        end
    end

    initial
    begin
        #40000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        pdh_cmd_t  c;
        bin_beat_t beat;
        int        pick;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        foreach (edge_tbl[k])
        begin
            edge_tbl[k] = '0;
        end
        foreach (bin_tally[k])
        begin
            bin_tally[k] = '0;
        end

        // Directed rows, run against edge k = k * 2^42 with open outer bounds.
        add_row('{mk_edge(0, 0), 1'b0, 0, 0});
        dir_tab[0].cmd.action = pdh_pkg::ACT_DUMP;
        dir_tab[0].typed = 1'b1;
        add_row('{mk_pair(0, 0, 0, 0, 0, 0), 1'b0, 0, 0});
        add_row('{mk_pair(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 1'b0, 0, 0});
        add_row('{mk_pair(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 1'b0, 0, 0});
        c = mk_edge(7'h7F, EDGE_TOP);
        c.action = ACT_NONE;
        add_row('{c, 1'b0, 0, 0});
        add_row('{mk_edge(pdh_pkg::IDX_W'(pdh_pkg::BINS + 1), 0), 1'b0, 0, 0});
        add_row('{mk_edge(7'h7F, 0), 1'b0, 0, 0});
        c = mk_edge(0, 0);
        c.action = pdh_pkg::ACT_DUMP;
        add_row('{c, 1'b1, 1, 2});
        // Exactly on edge 1, then just below it.
        add_row('{mk_pair(24'sd2097152, 0, 0, 0, 0, 0), 1'b0, 0, 0});
        add_row('{mk_pair(24'sd2097151, 0, 0, 0, 0, 0), 1'b0, 0, 0});
        // Raise the lower bound: below it drops, on it counts.
        add_row('{mk_edge(0, 5), 1'b0, 0, 0});
        add_row('{mk_pair(2, 0, 0, 0, 0, 0), 1'b0, 0, 0});
        add_row('{mk_pair(2, 1, 0, 0, 0, 0), 1'b0, 0, 0});
        // Lower the upper bound: on it drops, just below counts.
        add_row('{mk_edge(pdh_pkg::IDX_W'(pdh_pkg::BINS), 52'd1 << 44), 1'b0, 0, 0});
        add_row('{mk_pair(24'sd4194304, 0, 0, 0, 0, 0), 1'b0, 0, 0});
        add_row('{mk_pair(0, 24'sd4194303, 0, 0, 0, 0), 1'b0, 0, 0});
        add_row('{mk_edge(pdh_pkg::IDX_W'(pdh_pkg::BINS), EDGE_TOP), 1'b0, 0, 0});
        add_row('{mk_edge(0, 0), 1'b0, 0, 0});
        add_row('{c, 1'b0, 0, 0});
        // Break the order of the interior edges.
        add_row('{mk_edge(5, 0), 1'b0, 0, 0});
        add_row('{mk_pair(0, 0, 24'sd2097152, 0, 0, 0), 1'b0, 0, 0});
        add_row('{c, 1'b0, 0, 0});
        add_row('{mk_edge(5, 52'd5 << 42), 1'b0, 0, 0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Load every edge before the first pair; no unwritten edge is ever read.
        load_edges(SET_LINEAR);
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].typed)
            begin
                for (int k = 0; k < pdh_pkg::BINS; k++)
                begin
                    beat.bin   = pdh_pkg::BIN_W'(k);
                    beat.count = (k == 0) ? pdh_pkg::CNT_W'(dir_tab[i].lo_cnt)
                               : (k == pdh_pkg::BINS - 1) ? pdh_pkg::CNT_W'(dir_tab[i].hi_cnt)
                               : '0;
                    beat.last  = (k == pdh_pkg::BINS - 1);
                    queue_beat(beat);
                end
            end
            offer(dir_tab[i].cmd, !dir_tab[i].typed);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph % 2 == 0)
            begin
                load_edges((ph == 4) ? SET_SCRAMBLED : SET_LOG);
            end
            if (ph == 2)
            begin
                // Stall the output for a long stretch right as a dump starts,
                // while pairs keep arriving behind it.
                long_hold_due = 1'b1;
                c = rand_pair();
                c.action = pdh_pkg::ACT_DUMP;
                offer(c, 1'b1);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                c = rand_pair();
                if (pick >= 97)
                begin
                    c.action = pdh_pkg::ACT_DUMP;
                end
                else if (pick >= 94)
                begin
                    c.action = ACT_NONE;
                end
                else if (pick >= 91)
                begin
                    // Noise edge write; about half land outside the table.
                    c.action = pdh_pkg::ACT_EDGE;
                    c.idx = $urandom_range(0, 1)
                          ? pdh_pkg::IDX_W'($urandom_range(0, pdh_pkg::BINS))
                          : pdh_pkg::IDX_W'($urandom_range(pdh_pkg::BINS + 1, 127));
                end
                offer(c, 1'b1);
            end
            c = rand_pair();
            c.action = pdh_pkg::ACT_DUMP;
            offer(c, 1'b1);
            if (ph == 3 || $urandom_range(0, 2) == 0)
            begin
                pause_until_drained();
            end
        end

        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (pdh_pkg::BINS + 8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- pair_distance_histogram_top.f -----
+incdir+rtl/core
rtl/core/pdh_pkg.sv
rtl/core/pdh_sq.sv
rtl/core/pdh_edge_cell.sv
rtl/core/pdh_count_cell.sv
rtl/core/pair_distance_histogram_top.sv
test/tb.sv
